>>> sv/ahc_pkg.sv
// Shared types for the altitude hold controller: configuration set,
// controller commands and datapath status words.
// No dependencies.
`default_nettype none
package ahc_pkg;

	localparam int IN_W  = 136;
	localparam int OUT_W = 40;

	typedef struct packed {
		logic [7:0]  kp_pos;
		logic [7:0]  kp_vel;
		logic [7:0]  ki_vel;
		logic [7:0]  kd_vel;
		logic [10:0] hover_thr;
		logic [9:0]  home_m;
		logic [10:0] thr_floor;
		logic [10:0] thr_ceil;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic mode;
		logic div_step;
		logic climb;
		logic mul1;
		logic mul2;
		logic inc;
		logic sum;
		logic thr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic need_div;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

>>> sv/ahc_regs.sv
// APB-style configuration registers for the altitude hold controller.
// Depends on ahc_pkg.
`default_nettype none
module ahc_regs
	import ahc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);
	localparam logic [2:0] REG_KP_POS   = 3'd0;
	localparam logic [2:0] REG_KP_VEL   = 3'd1;
	localparam logic [2:0] REG_KI_VEL   = 3'd2;
	localparam logic [2:0] REG_KD_VEL   = 3'd3;
	localparam logic [2:0] REG_HOVER    = 3'd4;
	localparam logic [2:0] REG_HOME     = 3'd5;
	localparam logic [2:0] REG_FLOOR    = 3'd6;
	localparam logic [2:0] REG_CEIL     = 3'd7;

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_pos    <= 8'd50;
			cfg_q.kp_vel    <= 8'd120;
			cfg_q.ki_vel    <= 8'd45;
			cfg_q.kd_vel    <= 8'd1;
			cfg_q.hover_thr <= 11'd1500;
			cfg_q.home_m    <= 10'd10;
			cfg_q.thr_floor <= 11'd1100;
			cfg_q.thr_ceil  <= 11'd1900;
		end else if (wr) begin
			unique case (idx)
				REG_KP_POS: cfg_q.kp_pos    <= pwdata[7:0];
				REG_KP_VEL: cfg_q.kp_vel    <= pwdata[7:0];
				REG_KI_VEL: cfg_q.ki_vel    <= pwdata[7:0];
				REG_KD_VEL: cfg_q.kd_vel    <= pwdata[7:0];
				REG_HOVER:  cfg_q.hover_thr <= pwdata[10:0];
				REG_HOME:   cfg_q.home_m    <= pwdata[9:0];
				REG_FLOOR:  cfg_q.thr_floor <= pwdata[10:0];
				REG_CEIL:   cfg_q.thr_ceil  <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KP_POS: prdata = {24'd0, cfg_q.kp_pos};
			REG_KP_VEL: prdata = {24'd0, cfg_q.kp_vel};
			REG_KI_VEL: prdata = {24'd0, cfg_q.ki_vel};
			REG_KD_VEL: prdata = {24'd0, cfg_q.kd_vel};
			REG_HOVER:  prdata = {21'd0, cfg_q.hover_thr};
			REG_HOME:   prdata = {22'd0, cfg_q.home_m};
			REG_FLOOR:  prdata = {21'd0, cfg_q.thr_floor};
			REG_CEIL:   prdata = {21'd0, cfg_q.thr_ceil};
		endcase
	end
endmodule
`default_nettype wire

>>> sv/ahc_datapath.sv
// Datapath of the altitude hold controller: tick registers, mode and land
// detector state, descent divider, PI multipliers and throttle clamp.
// Depends on ahc_pkg; sequenced by ahc_ctrl.
`default_nettype none
module ahc_datapath
	import ahc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire cmd_t             cmd,
	input  wire logic [IN_W-1:0]  in_word,
	output sts_t                  sts,
	output logic      [OUT_W-1:0] res
);
	typedef enum logic [2:0] {
		CS_ZERO, CS_QUARTER, CS_HALF, CS_LAND, CS_GPS
	} climb_sel_t;

	// tick word
	logic hold_q, land_q, armed_q, gps_q, tlow_q;
	logic        [11:0] stick_q;
	logic signed [18:0] alt_q, baro_q;
	logic signed [15:0] vel_q, acc_q;
	logic        [15:0] dt_q;
	logic        [31:0] now_q;

	// controller state
	logic mode_q, hov_q, tk_q, gf_q;
	logic        [10:0] hb_q;
	logic signed [18:0] tgt_q;
	logic signed [9:0]  climb_q;
	logic signed [31:0] sum_q;
	logic signed [8:0]  term_q;
	logic        [31:0] ls_q, on_q;

	// per-tick working registers
	logic               act_q, cap_q, divu_q, dneg_q;
	climb_sel_t         sel_q;
	logic signed [28:0] p1_q;
	logic        [25:0] dq_q;
	logic        [17:0] rem_q;
	logic        [16:0] dabs_q;
	logic        [4:0]  dcnt_q;
	logic signed [10:0] vt_q;
	logic signed [19:0] m1_q, pv_q;
	logic signed [36:0] m2_q;
	logic signed [24:0] pd_q, inc_q;
	logic        [10:0] thr_q;
	logic        [OUT_W-1:0] res_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			hold_q  <= in_word[0];
			land_q  <= in_word[1];
			armed_q <= in_word[2];
			gps_q   <= in_word[3];
			tlow_q  <= in_word[4];
			stick_q <= in_word[16:5];
			alt_q   <= $signed(in_word[35:17]);
			vel_q   <= $signed(in_word[51:36]);
			acc_q   <= $signed(in_word[67:52]);
			dt_q    <= in_word[83:68];
			now_q   <= in_word[115:84];
			baro_q  <= $signed(in_word[134:116]);
		end
	end

	// ---------------- mode / land detector ----------------
	logic act, entry, hb_bad, lcond, cap, gf_b, gf_n, tk_b, hov_b, tk_n, hov_n, big;
	logic        [10:0] hb_n, hb_cl;
	logic        [31:0] ls_b, ls_n, on_n;
	logic signed [18:0] tgt_n;
	logic signed [12:0] diff, dm;
	logic signed [19:0] op_a, am5;
	logic        [25:0] num;
	logic signed [17:0] den;
	logic               need_div;
	climb_sel_t         sel_n;

	always_comb begin
		act    = (hold_q | land_q) & armed_q;
		entry  = act & ~mode_q;
		hb_bad = (hb_q < 11'd1250) || (hb_q > 11'd1750);
		if (cfg.hover_thr < 11'd1250)      hb_cl = 11'd1250;
		else if (cfg.hover_thr > 11'd1750) hb_cl = 11'd1750;
		else                               hb_cl = cfg.hover_thr;
		hb_n  = (entry && hb_bad) ? hb_cl : hb_q;
		ls_b  = entry ? now_q : ls_q;
		gf_b  = entry ? 1'b0 : gf_q;
		tk_b  = entry ? 1'b0 : tk_q;
		hov_b = entry ? 1'b0 : hov_q;
		lcond = (vel_q > -16'sd15) && (vel_q < 16'sd15) && (term_q <= -9'sd185)
			&& (alt_q < 19'sd500);
		if (lcond) begin
			on_n = now_q - ls_b;
			ls_n = ls_b;
		end else begin
			on_n = 32'd0;
			ls_n = now_q;
			gf_b = 1'b0;
		end
		cap  = ~gf_b && (on_n >= 32'd100);
		gf_n = gf_b | cap;

		diff = $signed({1'b0, stick_q}) - 13'sd1500;
		big  = (diff > 13'sd70) || (diff < -13'sd70);
		dm   = (diff > 13'sd0) ? diff - 13'sd70 : diff + 13'sd70;
		am5  = {alt_q[18], alt_q} - 20'sd500;
		num  = 26'(am5[17:0]) * 26'd200;
		den  = $signed({1'b0, 17'(17'(cfg.home_m) * 17'd100)}) - 18'sd500;

		tk_n     = tk_b;
		hov_n    = hov_b;
		tgt_n    = tgt_q;
		sel_n    = CS_ZERO;
		need_div = 1'b0;
		if (land_q) begin
			tk_n = 1'b0;
			if (gps_q) begin
				hov_n    = 1'b0;
				tgt_n    = (alt_q > 19'sd15000) ? 19'sd15000 : alt_q;
				sel_n    = CS_GPS;
				need_div = (alt_q > 19'sd500) && (den != 18'sd0);
			end else begin
				hov_n = 1'b1;
				sel_n = CS_LAND;
			end
		end else begin
			if (!tk_b && tlow_q && gf_n)               tk_n = 1'b1;
			else if (diff > 13'sd70 && vel_q >= 16'sd15) tk_n = 1'b0;
			if (tk_n || big) begin
				hov_n = 1'b0;
				sel_n = big ? CS_QUARTER : CS_ZERO;
			end else begin
				if (!hov_b) tgt_n = alt_q;
				hov_n = 1'b1;
				sel_n = CS_HALF;
			end
		end
		op_a = (sel_n == CS_QUARTER) ? 20'(dm) : ({tgt_n[18], tgt_n} - {alt_q[18], alt_q});
	end

	// ---------------- divider step ----------------
	logic [17:0] rem_sh;
	logic        dge;
	always_comb begin
		rem_sh = {rem_q[16:0], dq_q[25]};
		dge    = rem_sh >= {1'b0, dabs_q};
	end

	// ---------------- climb and velocity error ----------------
	logic signed [27:0] qs, cq;
	logic signed [28:0] raw, p4, p2;
	logic signed [9:0]  lim, climb_n;
	logic signed [16:0] ve;
	logic signed [10:0] vt_n;
	always_comb begin
		qs  = dneg_q ? -$signed({2'b00, dq_q}) : $signed({2'b00, dq_q});
		cq  = divu_q ? 28'sd50 + qs : 28'sd50;
		p4  = (p1_q + (p1_q[28] ? 29'sd3 : 29'sd0)) >>> 2;
		p2  = (p1_q + (p1_q[28] ? 29'sd1 : 29'sd0)) >>> 1;
		lim = 10'sd350;
		unique case (sel_q)
			CS_ZERO:    raw = 29'sd0;
			CS_QUARTER: raw = p4;
			CS_HALF:    raw = p2;
			CS_LAND: begin
				raw = p2;
				lim = (alt_q > 19'sd500) ? 10'sd250 : 10'sd83;
			end
			CS_GPS:     raw = -{cq[27], cq};
			default:    raw = 29'sd0;
		endcase
		if (raw > 29'(lim))       climb_n = lim;
		else if (raw < -29'(lim)) climb_n = -lim;
		else                      climb_n = raw[9:0];
		ve = 17'(climb_n) - 17'(vel_q);
		if (ve > 17'sd600)       vt_n = 11'sd600;
		else if (ve < -17'sd600) vt_n = -11'sd600;
		else                     vt_n = ve[10:0];
	end

	// ---------------- integrator ----------------
	logic signed [36:0] i7, i8, isel;
	logic signed [24:0] inc_n;
	logic               halve;
	logic signed [32:0] s33;
	logic signed [31:0] sum_n, sr;
	logic signed [15:0] sd;
	logic signed [8:0]  term_n;
	always_comb begin
		halve = hov_q && (climb_q > -10'sd100) && (climb_q < 10'sd100);
		i7    = (m2_q + (m2_q[36] ? 37'sd127 : 37'sd0)) >>> 7;
		i8    = (m2_q + (m2_q[36] ? 37'sd255 : 37'sd0)) >>> 8;
		isel  = halve ? i8 : i7;
		if (isel > 37'sd16384000)       inc_n = 25'sd16384000;
		else if (isel < -37'sd16384000) inc_n = -25'sd16384000;
		else                            inc_n = isel[24:0];

		s33 = {sum_q[31], sum_q} + 33'(inc_q);
		if (s33[32] != s33[31]) sum_n = s33[32] ? 32'sh80000000 : 32'sh7fffffff;
		else                    sum_n = s33[31:0];
		sr = (sum_n + (sum_n[31] ? 32'sd65535 : 32'sd0)) >>> 16;
		sd = sr[15:0];
		if (sd > 16'sd250)       term_n = 9'sd250;
		else if (sd < -16'sd250) term_n = -9'sd250;
		else                     term_n = sd[8:0];
	end

	// ---------------- throttle ----------------
	logic signed [19:0] pvs;
	logic signed [24:0] pds;
	logic signed [25:0] thr;
	logic        [10:0] thr_n;
	always_comb begin
		pvs = (pv_q + (pv_q[19] ? 20'sd31 : 20'sd0)) >>> 5;
		pds = (pd_q + (pd_q[24] ? 25'sd63 : 25'sd0)) >>> 6;
		thr = $signed({15'd0, hb_q}) + 26'(pvs) + 26'(term_q) - 26'(pds);
		if (thr < $signed({15'd0, cfg.thr_floor}))     thr_n = cfg.thr_floor;
		else if (thr > $signed({15'd0, cfg.thr_ceil})) thr_n = cfg.thr_ceil;
		else                                           thr_n = thr[10:0];
	end

	// target minus estimate, for the altitude reached flag
	logic signed [19:0] terr;
	assign terr = $signed({tgt_q[18], tgt_q} - {alt_q[18], alt_q});

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			hov_q   <= 1'b0;
			tk_q    <= 1'b0;
			gf_q    <= 1'b0;
			hb_q    <= 11'd0;
			tgt_q   <= 19'sd0;
			climb_q <= 10'sd0;
			sum_q   <= 32'sd0;
			term_q  <= 9'sd0;
			ls_q    <= 32'd0;
			on_q    <= 32'd0;
		end else begin
			if (cmd.mode) begin
				if (act) begin
					mode_q <= 1'b1;
					hov_q  <= hov_n;
					tk_q   <= tk_n;
					gf_q   <= gf_n;
					hb_q   <= hb_n;
					tgt_q  <= tgt_n;
					ls_q   <= ls_n;
					on_q   <= on_n;
				end else if (mode_q) begin
					mode_q  <= 1'b0;
					tk_q    <= 1'b0;
					climb_q <= 10'sd0;
					if (sum_q > 32'sd8192000)       sum_q <= 32'sd8192000;
					else if (sum_q < -32'sd8192000) sum_q <= -32'sd8192000;
					if (term_q > 9'sd125)       term_q <= 9'sd125;
					else if (term_q < -9'sd125) term_q <= -9'sd125;
					ls_q <= now_q;
					on_q <= 32'd0;
					gf_q <= 1'b0;
				end
			end
			if (cmd.climb) climb_q <= climb_n;
			if (cmd.sum) begin
				sum_q  <= sum_n;
				term_q <= term_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mode) begin
			act_q  <= act;
			cap_q  <= act & cap;
			sel_q  <= sel_n;
			divu_q <= need_div;
			p1_q   <= op_a * $signed({1'b0, cfg.kp_pos});
			dq_q   <= num;
			rem_q  <= 18'd0;
			dneg_q <= den[17];
			dabs_q <= den[17] ? 17'(-den) : den[16:0];
			dcnt_q <= 5'd0;
		end
		if (cmd.div_step) begin
			rem_q  <= dge ? rem_sh - {1'b0, dabs_q} : rem_sh;
			dq_q   <= {dq_q[24:0], dge};
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (cmd.climb) vt_q <= vt_n;
		if (cmd.mul1) begin
			m1_q <= vt_q * $signed({1'b0, cfg.ki_vel});
			pv_q <= vt_q * $signed({1'b0, cfg.kp_vel});
		end
		if (cmd.mul2) begin
			m2_q <= m1_q * $signed({1'b0, dt_q});
			pd_q <= acc_q * $signed({1'b0, cfg.kd_vel});
		end
		if (cmd.inc) inc_q <= inc_n;
		if (cmd.thr) thr_q <= thr_n;
		if (cmd.out_load) begin
			res_q[0]     <= act_q;
			res_q[11:1]  <= act_q ? thr_q : 11'd0;
			res_q[12]    <= tk_q;
			res_q[13]    <= gf_q;
			res_q[14]    <= cap_q;
			res_q[33:15] <= cap_q ? baro_q : 19'sd0;
			res_q[34]    <= gf_q && (on_q >= 32'd4000);
			res_q[35]    <= (terr > -20'sd50) && (terr < 20'sd50);
			res_q[39:36] <= 4'd0;
		end
	end

	assign sts.act      = act;
	assign sts.need_div = need_div;
	assign sts.div_done = dcnt_q == 5'd25;
	assign res          = res_q;
endmodule
`default_nettype wire

>>> sv/ahc_ctrl.sv
// Sequencer of the altitude hold controller: one-hot state machine that
// steps the datapath through one tick and owns the stream handshakes.
// Depends on ahc_pkg.
`default_nettype none
module ahc_ctrl
	import ahc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MODE  = 10'b0000000010,
		S_DIV   = 10'b0000000100,
		S_CLIMB = 10'b0000001000,
		S_MUL1  = 10'b0000010000,
		S_MUL2  = 10'b0000100000,
		S_INC   = 10'b0001000000,
		S_SUM   = 10'b0010000000,
		S_THR   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q, can_load;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign can_load = ~out_valid_q | m_tready;

	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == S_IDLE) & s_tvalid;
		cmd.mode     = state_q == S_MODE;
		cmd.div_step = state_q == S_DIV;
		cmd.climb    = state_q == S_CLIMB;
		cmd.mul1     = state_q == S_MUL1;
		cmd.mul2     = state_q == S_MUL2;
		cmd.inc      = state_q == S_INC;
		cmd.sum      = state_q == S_SUM;
		cmd.thr      = state_q == S_THR;
		cmd.out_load = (state_q == S_OUT) & can_load;

		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_n = S_MODE;
			S_MODE: begin
				if (!sts.act)         state_n = S_OUT;
				else if (sts.need_div) state_n = S_DIV;
				else                   state_n = S_CLIMB;
			end
			S_DIV:   if (sts.div_done) state_n = S_CLIMB;
			S_CLIMB: state_n = S_MUL1;
			S_MUL1:  state_n = S_MUL2;
			S_MUL2:  state_n = S_INC;
			S_INC:   state_n = S_SUM;
			S_SUM:   state_n = S_THR;
			S_THR:   state_n = S_OUT;
			S_OUT:   if (can_load) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)  out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_accept_to_mode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_MODE)
		else $error("accepted word did not start a tick");
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && sts.div_done |=> state_q == S_CLIMB)
		else $error("divider finish not followed by climb step");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && can_load |=> state_q == S_IDLE && out_valid_q)
		else $error("result word not posted on leaving output state");
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid_q && !m_tready |=> state_q == S_OUT)
		else $error("result overwritten while output full");
`endif
endmodule
`default_nettype wire

>>> sv/altitude_hold_controller_core.sv
// Altitude hold controller top: one result word per control tick word.
// An inactive tick goes from the mode step to the output step; an active one runs
// the climb, two multiply, increment, sum and throttle steps, after the GPS descent
// divider when it runs (26 steps, one quotient bit a cycle). A new tick word waits
// until the last is through; a held result word stalls the input until taken.
// Reset: arst_n clears all controller state and restores default gains.
`default_nettype none
module altitude_hold_controller_core
	import ahc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// hold_request, land_request, armed, gps_landing, stick_low,
	// throttle_stick, altitude_est, vertical_velocity, vertical_accel,
	// elapsed_us, now_ms, baro_altitude, zero pad
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// active, throttle_out, takeoff_in_progress, ground_latched,
	// ground_offset_update, ground_offset, landed, altitude_reached, zero pad
	output logic      [OUT_W-1:0] m_tdata,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [4:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready
);
	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ahc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	ahc_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .sts, .cmd
	);

	ahc_datapath u_dp (
		.clk, .arst_n, .cfg, .cmd, .in_word(s_tdata), .sts, .res(m_tdata)
	);
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for altitude_hold_controller_core: drives tick words and APB
// register writes, predicts or types every result word and compares field by field.
// Depends on ahc_pkg (IN_W, OUT_W) and the core RTL.
`timescale 1ns / 1ps
module tb_top;
	import ahc_pkg::*;

	typedef struct packed {
		logic               baro_pad;
		logic signed [18:0] baro;
		logic        [31:0] now;
		logic        [15:0] dt;
		logic signed [15:0] acc;
		logic signed [15:0] vel;
		logic signed [18:0] alt;
		logic        [11:0] stick;
		logic               thr_low;
		logic               gps;
		logic               armed;
		logic               land;
		logic               hold;
	} tick_t;

	typedef struct packed {
		logic [3:0]         pad;
		logic               reached;
		logic               landed;
		logic signed [18:0] offset;
		logic               capture;
		logic               ground;
		logic               takeoff;
		logic        [10:0] thr;
		logic               active;
	} ctl_res_t;

	typedef struct {
		bit       typed;
		tick_t    t;
		ctl_res_t r;
	} drow_t;

	localparam int WATCHDOG = 3000;
	localparam int SETTLE   = 40;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic [OUT_W-1:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic s_tready, pready;

	altitude_hold_controller_core dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor configuration copy and controller state
	longint g_kpp, g_kpv, g_kiv, g_kdv, g_hover, g_home, g_floor, g_ceil;
	bit st_mode, st_hov, st_tko, st_gnd;
	longint st_hb, st_tgt, st_climb, st_isum, st_iterm;
	bit [31:0] st_lstart, st_onland;

	ctl_res_t expected_q[$];
	int errors = 0, n_sent = 0, n_got = 0, n_active = 0, n_capture = 0, n_landed = 0;
	int idle_cnt = 0;
	bit no_idle = 0;
	int rx_hold_req = 0;
	bit [31:0] clk_ms = 0;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic ctl_res_t predict_tick(tick_t t);
		ctl_res_t r;
		longint stick, alt, vel, acc, dt, baro, climb, vt, inc, sum, ctrl, thr, diff, den;
		bit cap, act;
		r = '0;
		stick = longint'(t.stick);
		alt = longint'(t.alt);
		vel = longint'(t.vel);
		acc = longint'(t.acc);
		dt = longint'(t.dt);
		baro = longint'(t.baro);
		cap = 0;
		act = 0;
		thr = 0;
		if ((t.hold || t.land) && t.armed) begin
			if (!st_mode) begin
				st_mode = 1;
				st_hov = 0;
				st_tko = 0;
				if (st_hb < 1250 || st_hb > 1750) st_hb = clampl(g_hover, 1250, 1750);
				st_lstart = t.now;
				st_onland = 0;
				st_gnd = 0;
			end
			if (absl(vel) < 15 && st_iterm <= -185 && alt < 500) begin
				st_onland = t.now - st_lstart;
			end else begin
				st_lstart = t.now;
				st_onland = 0;
				st_gnd = 0;
			end
			if (!st_gnd && st_onland >= 100) begin
				st_gnd = 1;
				cap = 1;
			end
			climb = st_climb;
			if (t.land) begin
				st_tko = 0;
				if (t.gps) begin
					den = g_home * 100 - 500;
					st_hov = 0;
					st_tgt = alt > 15000 ? 15000 : alt;
					climb = 50;
					if (alt > 500 && den != 0) climb = 50 + (200 * (alt - 500)) / den;
					climb = -climb;
				end else begin
					st_hov = 1;
					climb = ((st_tgt - alt) * g_kpp) / 2;
					if (alt > 500) climb = clampl(climb, -250, 250);
					else climb = clampl(climb, -83, 83);
				end
			end else begin
				diff = stick - 1500;
				if (!st_tko && t.thr_low && st_gnd) st_tko = 1;
				else if (diff > 70 && vel >= 15) st_tko = 0;
				if (st_tko || absl(diff) > 70) begin
					st_hov = 0;
					if (absl(diff) <= 70) climb = 0;
					else climb = ((diff - (diff > 0 ? 70 : -70)) * g_kpp) / 4;
				end else begin
					if (!st_hov) begin
						st_hov = 1;
						st_tgt = alt;
					end
					climb = ((st_tgt - alt) * g_kpp) / 2;
				end
			end
			climb = clampl(climb, -350, 350);
			st_climb = climb;
			vt = clampl(climb - vel, -600, 600);
			inc = (vt * g_kiv * dt) / 128;
			if (st_hov && absl(climb) < 100) inc = inc / 2;
			inc = clampl(inc, -16384000, 16384000);
			sum = clampl(st_isum + inc, -64'sd2147483648, 64'sd2147483647);
			st_isum = sum;
			st_iterm = clampl(sum / 65536, -250, 250);
			ctrl = (vt * g_kpv) / 32 + st_iterm - (acc * g_kdv) / 64;
			thr = st_hb + ctrl;
			if (thr < g_floor) thr = g_floor;
			else if (thr > g_ceil) thr = g_ceil;
			act = 1;
		end else if (st_mode) begin
			st_mode = 0;
			st_tko = 0;
			st_climb = 0;
			st_isum = clampl(st_isum, -8192000, 8192000);
			st_iterm = clampl(st_iterm, -125, 125);
			st_lstart = t.now;
			st_onland = 0;
			st_gnd = 0;
		end
		r.active = act;
		r.thr = thr[10:0];
		r.takeoff = st_tko;
		r.ground = st_gnd;
		r.capture = cap;
		r.offset = cap ? baro[18:0] : '0;
		r.landed = st_gnd && st_onland >= 4000;
		r.reached = absl(st_tgt - alt) < 50;
		return r;
	endfunction

	task automatic reg_write(int idx, int val);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= 5'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		case (idx)
			0: g_kpp = val & 8'hff;
			1: g_kpv = val & 8'hff;
			2: g_kiv = val & 8'hff;
			3: g_kdv = val & 8'hff;
			4: g_hover = val & 11'h7ff;
			5: g_home = val & 10'h3ff;
			6: g_floor = val & 11'h7ff;
			default: g_ceil = val & 11'h7ff;
		endcase
	endtask

	// offer one tick word; a zero gap keeps tvalid high across words
	task automatic send_tick(tick_t t, bit typed, ctl_res_t r);
		int gap;
		ctl_res_t p;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= IN_W'(t);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		p = predict_tick(t);
		expected_q.push_back(typed ? r : p);
		n_sent++;
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic tick_t rand_tick();
		tick_t t;
		t.baro_pad = 0;
		t.hold = $urandom_range(0, 1);
		t.land = $urandom_range(0, 1);
		t.armed = $urandom_range(0, 3) != 0;
		t.gps = $urandom_range(0, 1);
		t.thr_low = $urandom_range(0, 1);
		t.stick = 12'($urandom_range(900, 2100));
		t.alt = 19'(int'($urandom_range(0, 400000)) - 200000);
		t.vel = 16'($urandom);
		t.acc = 16'($urandom);
		t.dt = 16'($urandom);
		t.now = $urandom;
		t.baro = 19'(int'($urandom_range(0, 400000)) - 200000);
		return t;
	endfunction

	function automatic tick_t mk(bit h, bit l, bit a, bit g, bit tl, int st, int alt, int vel,
		int acc, int dt, bit [31:0] now, int baro);
		tick_t t;
		t = '0;
		t.hold = h; t.land = l; t.armed = a; t.gps = g; t.thr_low = tl;
		t.stick = 12'(st); t.alt = 19'(alt); t.vel = 16'(vel); t.acc = 16'(acc);
		t.dt = 16'(dt); t.now = now; t.baro = 19'(baro);
		return t;
	endfunction

	// random part of one phase: mostly flight episodes, some noise
	task automatic random_phase(int n, int phase);
		tick_t t;
		int kind, len, base_n;
		base_n = n_sent;
		while (n_sent - base_n < n) begin
			kind = $urandom_range(0, 9);
			no_idle = (kind == 9);
			if (phase == 2 && rx_hold_req == 0 && n_sent - base_n > n / 2) rx_hold_req = 1;
			if (phase == 3 && n_sent - base_n > n / 2 && n_sent - base_n < n / 2 + 10)
				drain();
			if ($urandom_range(0, 15) == 0) clk_ms = 32'hffffffff - $urandom_range(0, 3000);
			if (kind == 0) begin
				send_tick(rand_tick(), 0, '0);
			end else if (kind <= 3) begin
				len = $urandom_range(40, 90);
				for (int i = 0; i < len; i++) begin
					t = rand_tick();
					clk_ms += $urandom_range(20, 150);
					t.now = clk_ms;
					t.armed = 1;
					t.land = i < len - 8;
					t.hold = !t.land || $urandom_range(0, 1);
					t.gps = 0;
					t.alt = 19'($urandom_range(0, 499));
					t.vel = 16'(int'($urandom_range(0, 28)) - 14);
					t.dt = 16'($urandom_range(10000, 65535));
					if (!t.land) t.stick = 12'($urandom_range(1400, 1700));
					send_tick(t, 0, '0);
				end
			end else if (kind == 4) begin
				len = $urandom_range(3, 12);
				for (int i = 0; i < len; i++) begin
					t = rand_tick();
					clk_ms += 20;
					t.now = clk_ms;
					t.armed = 1; t.land = 1; t.gps = 1;
					send_tick(t, 0, '0);
				end
			end else begin
				len = $urandom_range(5, 25);
				for (int i = 0; i < len; i++) begin
					t = rand_tick();
					clk_ms += 20;
					t.now = clk_ms;
					t.armed = kind != 7 || i < len - 2;
					t.hold = 1; t.land = 0;
					t.stick = 12'($urandom_range(0, 3) == 0 ? $urandom_range(900, 2100)
						: $urandom_range(1420, 1580));
					t.alt = 19'(int'($urandom_range(0, 4000)) - 2000);
					t.vel = 16'(int'($urandom_range(0, 600)) - 300);
					send_tick(t, 0, '0);
				end
			end
		end
		no_idle = 0;
	endtask

	// receiver: random hold-offs plus one long stall
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req == 1) begin
				rx_hold_req = 0;
				m_tready <= 0;
				repeat (400) @(posedge clk);
				rx_hold_req = 2;
			end
			gap = no_idle ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		ctl_res_t got, exp_r;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (m_tvalid && m_tready) begin
			got = ctl_res_t'(m_tdata);
			n_got++;
			if (got.active) n_active++;
			if (got.capture) n_capture++;
			if (got.landed) n_landed++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %p", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got.active !== exp_r.active || got.thr !== exp_r.thr
					|| got.takeoff !== exp_r.takeoff || got.ground !== exp_r.ground
					|| got.capture !== exp_r.capture || got.offset !== exp_r.offset
					|| got.landed !== exp_r.landed || got.reached !== exp_r.reached
					|| got.pad !== exp_r.pad) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at word %0d: exp %p got %p", n_got, exp_r, got);
				end
			end
		end
		if (idle_cnt >= WATCHDOG) begin
			$display("watchdog: no traffic for %0d cycles", WATCHDOG);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		drow_t dtab[$];
		int cfg[6][8];
		ctl_res_t z;
		cfg[1] = '{0, 0, 0, 0, 1000, 0, 1000, 2000};
		cfg[2] = '{255, 255, 255, 255, 2000, 1000, 1000, 2000};
		cfg[3] = '{50, 120, 45, 1, 1500, 5, 1100, 1900};
		cfg[4] = '{100, 60, 200, 30, 1250, 500, 2000, 1000};
		cfg[5] = '{20, 200, 10, 0, 1750, 1, 1300, 1700};
		g_kpp = 50; g_kpv = 120; g_kiv = 45; g_kdv = 1;
		g_hover = 1500; g_home = 10; g_floor = 1100; g_ceil = 1900;
		st_mode = 0; st_hov = 0; st_tko = 0; st_gnd = 0;
		st_hb = 0; st_tgt = 0; st_climb = 0; st_isum = 0; st_iterm = 0;
		st_lstart = 0; st_onland = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: typed results for idle ticks, predictor elsewhere
		z = '0; z.reached = 1;
		dtab.push_back('{1, mk(0, 0, 0, 0, 0, 1500, 0, 0, 0, 0, 0, 0), z});
		z = '0;
		dtab.push_back('{1, mk(1, 1, 0, 1, 1, 2100, 200000, 32767, 32767, 65535,
			32'hffffffff, 200000), z});
		dtab.push_back('{1, mk(0, 0, 1, 0, 0, 900, -200000, -32768, -32768, 0, 0,
			-200000), z});
		dtab.push_back('{0, mk(1, 0, 1, 0, 0, 1500, 1000, 0, 0, 20000, 100, 5), z});
		dtab.push_back('{0, mk(1, 0, 1, 0, 0, 2100, 1000, 32767, 32767, 65535, 120, 5), z});
		dtab.push_back('{0, mk(1, 0, 1, 0, 1, 900, -200000, -32768, -32768, 65535, 140, 5), z});
		dtab.push_back('{0, mk(1, 0, 1, 0, 0, 1571, 200000, 14, 0, 1, 160, 5), z});
		dtab.push_back('{0, mk(0, 1, 1, 1, 0, 1500, 200000, 0, 0, 65535, 180, 5), z});
		dtab.push_back('{0, mk(0, 1, 1, 1, 0, 1500, 400, 0, 0, 65535, 200, 5), z});
		dtab.push_back('{0, mk(0, 1, 1, 0, 0, 1500, -200000, 0, 0, 65535, 220, 5), z});
		dtab.push_back('{0, mk(0, 1, 1, 0, 0, 1500, 300, 0, 0, 65535, 240, 5), z});
		for (int i = 0; i < 12; i++)
			dtab.push_back('{0, mk(0, 1, 1, 0, 0, 1500, 100, 0, 100, 65535,
				32'hfffffe00 + 32'(i * 60), -777), z});
		dtab.push_back('{0, mk(1, 0, 1, 0, 1, 1500, 100, 0, 0, 65535, 1000, 9), z});
		dtab.push_back('{0, mk(0, 0, 1, 0, 0, 1500, 100, 0, 0, 65535, 1100, 9), z});
		foreach (dtab[i]) send_tick(dtab[i].t, dtab[i].typed, dtab[i].r);
		random_phase(300, 0);

		for (int ph = 1; ph < 6; ph++) begin
			drain();
			for (int k = 0; k < 8; k++) reg_write(k, cfg[ph][k]);
			random_phase(320, ph);
		end
		drain();
		$display("sent %0d tick words, checked %0d results: %0d active, %0d captures, %0d landed",
			n_sent, n_got, n_active, n_capture, n_landed);
		$display("ran six gain and throttle window settings, including a long output stall");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d errors, %0d results missing", errors, expected_q.size());
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
